[design/lbp_pkg.sv]
// Shared constants, types and the uniform-bin table for the LBP operator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lbp_pkg;

   // Image geometry and field widths
   localparam int MAX_WIDTH    = 128;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int WIDTH_W      = 8;
   localparam int HEIGHT_W     = 12;
   localparam int PIXEL_W      = 8;
   localparam int CODE_W       = 8;
   localparam int BIN_W        = 6;
   localparam int CSR_DATA_W   = 12;
   localparam int LINE_DATA_W  = 2 * PIXEL_W;

   localparam logic [WIDTH_W-1:0]  MIN_WIDTH         = WIDTH_W'(3);
   localparam logic [WIDTH_W-1:0]  CLAMP_WIDTH       = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] MIN_HEIGHT        = HEIGHT_W'(3);
   localparam logic [WIDTH_W-1:0]  RESET_WIDTH       = WIDTH_W'(112);
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT      = HEIGHT_W'(112);
   localparam logic [BIN_W-1:0]    MIXED_PATTERN_BIN = BIN_W'(58);

   // Register indexes of the configuration port
   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Write port of the line memory
   typedef struct packed {
      logic                   en;
      logic [COL_W-1:0]       addr;
      logic [LINE_DATA_W-1:0] data;
   } line_write_type;

   typedef logic [(1<<CODE_W)-1:0][BIN_W-1:0] bin_table_type;

   // A code is uniform when it has at most two circular transitions
   function automatic logic code_is_uniform(input logic [CODE_W-1:0] v);
      logic [CODE_W-1:0] t;
      t = v ^ {v[0], v[CODE_W-1:1]};
      return ($countones(t) <= 2);
   endfunction

   // Rank uniform codes in ascending order; all others map to the catch-all bin
   function automatic bin_table_type build_bin_table();
      bin_table_type tbl;
      int            rank;
      rank = 0;
      for (int i = 0; i < (1 << CODE_W); i++) begin
         if (code_is_uniform(CODE_W'(i))) begin
            tbl[i] = BIN_W'(rank);
            rank++;
         end else begin
            tbl[i] = MIXED_PATTERN_BIN;
         end
      end
      return tbl;
   endfunction

   localparam bin_table_type UNIFORM_BIN_TABLE = build_bin_table();

endpackage

`default_nettype wire

[design/lbp_line_mem.sv]
// Line memory: both row stores packed in one 128 x 16 synchronous RAM.
// Depends on lbp_pkg; read data is registered and forwarded on same-entry write.
`default_nettype none

module lbp_line_mem (
   input  wire logic                           clock,
   input  wire logic                           rd_en,
   input  wire logic [lbp_pkg::COL_W-1:0]      rd_addr,
   input  wire lbp_pkg::line_write_type        wr,
   output      logic [lbp_pkg::LINE_DATA_W-1:0] rd_data
);

   logic [lbp_pkg::LINE_DATA_W-1:0] mem [lbp_pkg::MAX_WIDTH];
   logic [lbp_pkg::LINE_DATA_W-1:0] rd_data_ff;

   // Write back the updated column
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read; forward a write to the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/lbp_window.sv]
// 3x3 window registers and the eight neighbor comparisons.
// Depends on lbp_pkg; fed by the line memory read word and the current pixel.
`default_nettype none

module lbp_window (
   input  wire logic                          clock,
   input  wire logic                          shift,
   input  wire logic [lbp_pkg::PIXEL_W-1:0]   top_pixel,
   input  wire logic [lbp_pkg::PIXEL_W-1:0]   mid_pixel,
   input  wire logic [lbp_pkg::PIXEL_W-1:0]   bot_pixel,
   output      logic [lbp_pkg::CODE_W-1:0]    code
);

   // Columns 0 and 1 of the window; column 0 after a shift is the old column 1
   logic [lbp_pkg::PIXEL_W-1:0] top1_ff, mid1_ff, bot1_ff;
   logic [lbp_pkg::PIXEL_W-1:0] top2_ff, mid2_ff, bot2_ff;
   logic [lbp_pkg::PIXEL_W-1:0] center;

   // Advance the window by one column
   always_ff @(posedge clock) begin
      if (shift) begin
         top1_ff <= top2_ff;
         mid1_ff <= mid2_ff;
         bot1_ff <= bot2_ff;
         top2_ff <= top_pixel;
         mid2_ff <= mid_pixel;
         bot2_ff <= bot_pixel;
      end
   end

   // Compare the shifted window against its center, clockwise from top-left
   always_comb begin
      center  = mid2_ff;
      code[7] = (top1_ff   >= center);
      code[6] = (top2_ff   >= center);
      code[5] = (top_pixel >= center);
      code[4] = (mid_pixel >= center);
      code[3] = (bot_pixel >= center);
      code[2] = (bot2_ff   >= center);
      code[1] = (bot1_ff   >= center);
      code[0] = (mid1_ff   >= center);
   end

endmodule

`default_nettype wire

[design/uniform_lbp_operator.sv]
// Streaming uniform LBP operator: top level with position counters and pipeline.
// Depends on lbp_pkg, lbp_line_mem and lbp_window.
//
// Usage:
//   Input channel req_*: one gray pixel per word in raster order; req_frame_start
//   marks the first pixel of a frame and resets the position to row 0, column 0.
//   Result channel rsp_*: one word per interior pixel (both row and column at
//   least 2), carrying the 8-bit LBP code, the uniform bin (58 = non-uniform),
//   the interior column and row, and rsp_frame_end on the last result of a frame.
//   Border pixels produce no word.
//   Configuration csr_*: index 0 image width (3..128), index 1 image height;
//   write only while the block is idle. Widths outside range are clamped.
//   Throughput: one pixel per cycle while the output is not stalled. A pixel
//   passes the line memory read (stage 1), the code register (stage 2) and the
//   output register, from which its result word is offered.
//   The pipeline advances as one; when the receiver holds rsp_ready low with a
//   word waiting, the whole pipeline and req_ready stall until it is taken.
//   Reset clears the position counters, pipeline valids and sets both size
//   registers to 112. The line memory is not cleared and needs no sweep.
`default_nettype none

module uniform_lbp_operator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // pixel input
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [lbp_pkg::PIXEL_W-1:0]      req_pixel,
   input  wire logic                             req_frame_start,
   // result output
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [lbp_pkg::CODE_W-1:0]       rsp_lbp_code,
   output      logic [lbp_pkg::BIN_W-1:0]        rsp_uniform_bin,
   output      logic [lbp_pkg::COL_W-1:0]        rsp_out_column,
   output      logic [lbp_pkg::HEIGHT_W-1:0]     rsp_out_row,
   output      logic                             rsp_frame_end,
   // configuration
   input  wire logic                             csr_wr_en,
   input  wire lbp_pkg::csr_index_type           csr_index,
   input  wire logic [lbp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COL_W = lbp_pkg::COL_W;
   localparam int ROW_W = lbp_pkg::HEIGHT_W;

   // Configuration registers
   logic [lbp_pkg::WIDTH_W-1:0]  width_ff;
   logic [ROW_W-1:0]             height_ff;
   logic [lbp_pkg::WIDTH_W-1:0]  width_eff;
   logic [ROW_W-1:0]             height_eff;

   // Position of the next pixel
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Current pixel position and frame flags
   logic [COL_W-1:0] cur_col;
   logic [ROW_W-1:0] cur_row;
   logic             last_col;
   logic             last_row;

   logic flow_en;
   logic accept;

   // Stage 1: memory read in flight
   logic                        s1_valid_ff;
   logic [lbp_pkg::PIXEL_W-1:0] s1_pixel_ff;
   logic [COL_W-1:0]            s1_col_ff;
   logic [ROW_W-1:0]            s1_row_ff;
   logic                        s1_emit_ff;
   logic                        s1_frame_end_ff;

   // Stage 2: code formed
   logic                        s2_valid_ff;
   logic [lbp_pkg::CODE_W-1:0]  s2_code_ff;
   logic [COL_W-1:0]            s2_col_ff;
   logic [ROW_W-1:0]            s2_row_ff;
   logic                        s2_frame_end_ff;

   // Output register
   logic                        rsp_valid_ff;
   logic [lbp_pkg::CODE_W-1:0]  rsp_code_ff;
   logic [lbp_pkg::BIN_W-1:0]   rsp_bin_ff;
   logic [COL_W-1:0]            rsp_col_ff;
   logic [ROW_W-1:0]            rsp_row_ff;
   logic                        rsp_frame_end_ff;

   logic [lbp_pkg::LINE_DATA_W-1:0] line_rd;
   lbp_pkg::line_write_type         line_wr;
   logic [lbp_pkg::CODE_W-1:0]      win_code;

   // Hold configuration; to be written only while idle, which the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lbp_pkg::RESET_WIDTH;
         height_ff <= lbp_pkg::RESET_HEIGHT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lbp_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[lbp_pkg::WIDTH_W-1:0];
            lbp_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp sizes into range
   always_comb begin
      if (width_ff < lbp_pkg::MIN_WIDTH) begin
         width_eff = lbp_pkg::MIN_WIDTH;
      end else if (width_ff > lbp_pkg::CLAMP_WIDTH) begin
         width_eff = lbp_pkg::CLAMP_WIDTH;
      end else begin
         width_eff = width_ff;
      end
      height_eff = (height_ff < lbp_pkg::MIN_HEIGHT) ? lbp_pkg::MIN_HEIGHT : height_ff;
   end

   // Whole pipeline advances when the output register is free or being taken
   assign flow_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = flow_en;
   assign accept    = req_valid && flow_en;

   // Position of this pixel and the next one
   always_comb begin
      cur_col  = req_frame_start ? '0 : col_ff;
      cur_row  = req_frame_start ? '0 : row_ff;
      last_col = ({1'b0, cur_col} + lbp_pkg::WIDTH_W'(1)) >= width_eff;
      last_row = ({1'b0, cur_row} + (ROW_W+1)'(1)) >= {1'b0, height_eff};
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : cur_row + ROW_W'(1);
      end else begin
         col_in = cur_col + COL_W'(1);
         row_in = cur_row;
      end
   end

   // Advance the position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (flow_en) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff && s1_emit_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (flow_en) begin
         s1_pixel_ff      <= req_pixel;
         s1_col_ff        <= cur_col;
         s1_row_ff        <= cur_row;
         s1_emit_ff       <= (cur_col >= COL_W'(2)) && (cur_row >= ROW_W'(2));
         s1_frame_end_ff  <= last_col && last_row;

         s2_code_ff       <= win_code;
         s2_col_ff        <= s1_col_ff - COL_W'(2);
         s2_row_ff        <= s1_row_ff - ROW_W'(2);
         s2_frame_end_ff  <= s1_frame_end_ff;

         rsp_code_ff      <= s2_code_ff;
         rsp_bin_ff       <= lbp_pkg::UNIFORM_BIN_TABLE[s2_code_ff];
         rsp_col_ff       <= s2_col_ff;
         rsp_row_ff       <= s2_row_ff;
         rsp_frame_end_ff <= s2_frame_end_ff;
      end
   end

   // Write back: upper takes the old middle, middle takes the new pixel
   always_comb begin
      line_wr.en   = s1_valid_ff && flow_en;
      line_wr.addr = s1_col_ff;
      line_wr.data = {line_rd[lbp_pkg::PIXEL_W-1:0], s1_pixel_ff};
   end

   lbp_line_mem u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .wr      (line_wr),
      .rd_data (line_rd)
   );

   lbp_window u_window (
      .clock     (clock),
      .shift     (s1_valid_ff && flow_en),
      .top_pixel (line_rd[lbp_pkg::LINE_DATA_W-1:lbp_pkg::PIXEL_W]),
      .mid_pixel (line_rd[lbp_pkg::PIXEL_W-1:0]),
      .bot_pixel (s1_pixel_ff),
      .code      (win_code)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lbp_code    = rsp_code_ff;
   assign rsp_uniform_bin = rsp_bin_ff;
   assign rsp_out_column  = rsp_col_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_frame_end   = rsp_frame_end_ff;

endmodule

`default_nettype wire

[design/lbp_checker.sv]
// Port-level checks for the LBP operator, bound to the top level.
// Depends on lbp_pkg.
`default_nettype none

module lbp_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [lbp_pkg::CODE_W-1:0]     rsp_lbp_code,
   input wire logic [lbp_pkg::BIN_W-1:0]      rsp_uniform_bin,
   input wire logic [lbp_pkg::COL_W-1:0]      rsp_out_column,
   input wire logic [lbp_pkg::HEIGHT_W-1:0]   rsp_out_row,
   input wire logic                           rsp_frame_end
);

   // Hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lbp_code)
         && $stable(rsp_uniform_bin) && $stable(rsp_out_column)
         && $stable(rsp_out_row) && $stable(rsp_frame_end))
      else $error("stalled result word changed");

   // Drop input readiness while a result word is held back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while output stalled");

   // Bin agrees with the transition count of the code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_uniform_bin == lbp_pkg::MIXED_PATTERN_BIN) ==
         ($countones(rsp_lbp_code ^ {rsp_lbp_code[0], rsp_lbp_code[7:1]}) > 2)))
      else $error("uniform bin does not match code");

   // Interior column and bin stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_column <= lbp_pkg::COL_W'(lbp_pkg::MAX_WIDTH - 3))
         && (rsp_uniform_bin <= lbp_pkg::MIXED_PATTERN_BIN))
      else $error("result field out of range");

endmodule

bind uniform_lbp_operator lbp_checker u_lbp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_lbp_code    (rsp_lbp_code),
   .rsp_uniform_bin (rsp_uniform_bin),
   .rsp_out_column  (rsp_out_column),
   .rsp_out_row     (rsp_out_row),
   .rsp_frame_end   (rsp_frame_end)
);

`default_nettype wire

[dv/lbp_result_checker.sv]
// Result checker for the uniform LBP operator: follows size writes and accepted
// pixels, predicts every result word and compares it with the word the block sends.
// Depends on lbp_pkg for field widths, size limits and register indexes.
module lbp_result_checker
   import lbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [PIXEL_W-1:0]    req_pixel,
   input  logic                  req_frame_start,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [CODE_W-1:0]     rsp_lbp_code,
   input  logic [BIN_W-1:0]      rsp_uniform_bin,
   input  logic [COL_W-1:0]      rsp_out_column,
   input  logic [HEIGHT_W-1:0]   rsp_out_row,
   input  logic                  rsp_frame_end,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_results,
   output int                    results_checked,
   output int                    frame_ends_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CODE_W-1:0]   lbp_code;
      logic [BIN_W-1:0]    uniform_bin;
      logic [COL_W-1:0]    column;
      logic [HEIGHT_W-1:0] row;
      logic                frame_end;
   } lbp_word_type;

   // Predictor state: two rows above, 3x3 neighborhood, position of the next pixel
   logic [PIXEL_W-1:0]  row_two_up [MAX_WIDTH];
   logic [PIXEL_W-1:0]  row_one_up [MAX_WIDTH];
   logic [PIXEL_W-1:0]  nbhd [3][3];
   logic [COL_W-1:0]    next_col;
   logic [HEIGHT_W-1:0] next_row;
   logic [WIDTH_W-1:0]  width_reg;
   logic [HEIGHT_W-1:0] height_reg;

   logic [BIN_W-1:0]    bin_of_code [1 << CODE_W];
   lbp_word_type        expected_words [$];
   int                  mismatches;
   int                  checked;
   int                  frame_ends;

   // Rank codes with at most two circular bit flips; everything else is non-uniform
   initial begin : build_bins
      int code, b, flips, rank;
      rank = 0;
      for (code = 0; code < (1 << CODE_W); code++) begin
         flips = 0;
         for (b = 0; b < CODE_W; b++)
            if (code[b] != code[(b + 1) % CODE_W])
               flips++;
         if (flips <= 2) begin
            bin_of_code[code] = BIN_W'(rank);
            rank++;
         end else begin
            bin_of_code[code] = MIXED_PATTERN_BIN;
         end
      end
   end

   // Advance the window by one pixel and queue the word it produces, if any
   task automatic predict_lbp(input logic [PIXEL_W-1:0] gray, input logic start);
      int unsigned w, h, c, r, i;
      logic [PIXEL_W-1:0] ctr;
      logic [CODE_W-1:0]  code;
      logic               last_col, last_row;
      lbp_word_type       word;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = height_reg;
      if (h < 3) h = 3;
      if (start) begin
         next_col = '0;
         next_row = '0;
      end
      c = next_col;
      r = next_row;
      for (i = 0; i < 3; i++) begin
         nbhd[i][0] = nbhd[i][1];
         nbhd[i][1] = nbhd[i][2];
      end
      nbhd[0][2] = row_two_up[c];
      nbhd[1][2] = row_one_up[c];
      nbhd[2][2] = gray;
      row_two_up[c] = row_one_up[c];
      row_one_up[c] = gray;
      last_col = (c + 1) >= w;
      last_row = (r + 1) >= h;
      // border pixels give no word
      if (r >= 2 && c >= 2) begin
         ctr  = nbhd[1][1];
         code = {nbhd[0][0] >= ctr, nbhd[0][1] >= ctr, nbhd[0][2] >= ctr,
                 nbhd[1][2] >= ctr, nbhd[2][2] >= ctr, nbhd[2][1] >= ctr,
                 nbhd[2][0] >= ctr, nbhd[1][0] >= ctr};
         word.lbp_code    = code;
         word.uniform_bin = bin_of_code[code];
         word.column      = COL_W'(c - 2);
         word.row         = HEIGHT_W'(r - 2);
         word.frame_end   = last_col && last_row;
         expected_words.push_back(word);
      end
      // wrap at the row end, and at the frame end with no start marker needed
      if (last_col) begin
         next_col = '0;
         next_row = last_row ? '0 : HEIGHT_W'(r + 1);
      end else begin
         next_col = COL_W'(c + 1);
      end
   endtask

   // Compare one accepted result word with the oldest prediction
   task automatic check_word();
      lbp_word_type want;
      if (expected_words.size() == 0) begin
         if (mismatches < 10)
            $display("%0t: unexpected result word: code %02h bin %0d col %0d row %0d",
                     $time, rsp_lbp_code, rsp_uniform_bin, rsp_out_column, rsp_out_row);
         mismatches++;
      end else begin
         want = expected_words.pop_front();
         if (rsp_lbp_code !== want.lbp_code || rsp_uniform_bin !== want.uniform_bin ||
             rsp_out_column !== want.column || rsp_out_row !== want.row ||
             rsp_frame_end !== want.frame_end) begin
            if (mismatches < 10)
               $display("%0t: mismatch, expected code %02h bin %0d col %0d row %0d end %0b",
                        $time, want.lbp_code, want.uniform_bin, want.column, want.row,
                        want.frame_end, " / got code %02h bin %0d col %0d row %0d end %0b",
                        rsp_lbp_code, rsp_uniform_bin, rsp_out_column, rsp_out_row,
                        rsp_frame_end);
            mismatches++;
         end
         checked++;
         if (want.frame_end)
            frame_ends++;
      end
   endtask

   // Sample both channels and the register port at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         next_col   = '0;
         next_row   = '0;
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         expected_words.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_IMAGE_WIDTH)
               width_reg = csr_wdata[WIDTH_W-1:0];
            else
               height_reg = csr_wdata[HEIGHT_W-1:0];
         end
         if (rsp_valid && rsp_ready)
            check_word();
         if (req_valid && req_ready)
            predict_lbp(req_pixel, req_frame_start);
      end
      fail_count      <= mismatches;
      pending_results <= expected_words.size();
      results_checked <= checked;
      frame_ends_seen <= frame_ends;
   end

endmodule

[dv/tb_uniform_lbp_operator.sv]
// Testbench top for the uniform LBP operator: clock, reset, pixel stimulus,
// size settings and the verdict. Depends on lbp_pkg, the block and lbp_result_checker.
module tb_uniform_lbp_operator;
   timeunit 1ns;
   timeprecision 1ps;
   import lbp_pkg::*;

   localparam int STALL_LIMIT = 2000;

   // Directed frame, 3 wide and 5 high, first pixel in the low byte:
   // gives a non-uniform code, the all-ones code and the all-zeros code
   localparam logic [15*PIXEL_W-1:0] DIRECTED_FRAME = {
      8'd0,   8'd0,   8'd0,
      8'd0,   8'd255, 8'd0,
      8'd0,   8'd0,   8'd0,
      8'd0,   8'd128, 8'd0,
      8'd255, 8'd0,   8'd255
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIXEL_W-1:0]    req_pixel = '0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CODE_W-1:0]     rsp_lbp_code;
   logic [BIN_W-1:0]      rsp_uniform_bin;
   logic [COL_W-1:0]      rsp_out_column;
   logic [HEIGHT_W-1:0]   rsp_out_row;
   logic                  rsp_frame_end;
   logic                  csr_wr_en = 1'b0;
   csr_index_type         csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int                    fail_count;
   int                    pending_results;
   int                    results_checked;
   int                    frame_ends_seen;
   int                    stall_cycles = 0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    pixels_sent = 0;
   int                    settings_used = 0;
   logic [WIDTH_W-1:0]    cur_width = RESET_WIDTH;
   logic [HEIGHT_W-1:0]   cur_height = RESET_HEIGHT;

   uniform_lbp_operator u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_lbp_code    (rsp_lbp_code),
      .rsp_uniform_bin (rsp_uniform_bin),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_row     (rsp_out_row),
      .rsp_frame_end   (rsp_frame_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   lbp_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_lbp_code    (rsp_lbp_code),
      .rsp_uniform_bin (rsp_uniform_bin),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_row     (rsp_out_row),
      .rsp_frame_end   (rsp_frame_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .results_checked (results_checked),
      .frame_ends_seen (frame_ends_seen)
   );

   always #5 clock = ~clock;

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Count cycles in which no word moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   // Offer one pixel word after a random gap and hold it until it is taken
   task automatic send_pixel(input logic [PIXEL_W-1:0] gray, input logic start);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel       <= gray;
      req_frame_start <= start;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   // Hold the sender until every predicted word has come, then let the pipe empty
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Write both size registers on back-to-back cycles
   task automatic write_sizes(input logic [WIDTH_W-1:0] w, input logic [HEIGHT_W-1:0] h);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_width  = w;
      cur_height = h;
      settings_used++;
   endtask

   // Stream frames of random texture; a start marker opens most frames, a few
   // frames wrap on their own, and stray markers restart the position
   task automatic stream_frames(input int count, input bit open_frame, input int stray_pct);
      int                 w, h, frame_len, pos, n;
      logic               start;
      logic [PIXEL_W-1:0] gray;
      w = (cur_width < 3) ? 3 : ((cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width);
      h = (cur_height < 3) ? 3 : cur_height;
      frame_len = w * h;
      pos = open_frame ? 0 : 1;
      for (n = 0; n < count; n++) begin
         start = (n == 0 && open_frame) ||
                 (pos == 0 && $urandom_range(0, 99) < 80) ||
                 ($urandom_range(0, 99) < stray_pct);
         if (start)
            pos = 0;
         case ($urandom_range(0, 2))
            0:       gray = PIXEL_W'($urandom_range(0, 255));
            1:       gray = PIXEL_W'($urandom_range(0, 2));
            default: gray = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         endcase
         send_pixel(gray, start);
         pos = (pos + 1) % frame_len;
      end
   endtask

   initial begin : stimulus
      int i, fails;
      bit timed_out;
      timed_out = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            send_idle_pct = 31;
            recv_idle_pct = 55;
            // directed frame, then pixels that run on past its end with no marker
            write_sizes(8'd3, 12'd5);
            for (i = 0; i < 21; i++)
               send_pixel((i < 15) ? DIRECTED_FRAME[i*PIXEL_W +: PIXEL_W]
                                   : PIXEL_W'($urandom), i == 0);
            // sizes below range clamp to 3x3
            drain_results();
            write_sizes(8'd0, 12'd0);
            stream_frames(90, 1'b1, 2);
            // width above range clamps to the line store size
            drain_results();
            write_sizes(8'd255, 12'd3);
            stream_frames(384, 1'b1, 0);
            send_idle_pct = 55;
            recv_idle_pct = 31;
            // tall narrow frame, then drop the height below the current row
            drain_results();
            write_sizes(8'd2, 12'd4095);
            stream_frames(150, 1'b1, 0);
            drain_results();
            write_sizes(8'd2, 12'd1);
            stream_frames(60, 1'b0, 1);
            // drop the width below the current column in mid-row
            drain_results();
            write_sizes(8'd20, 12'd6);
            stream_frames(150, 1'b1, 0);
            drain_results();
            write_sizes(8'd5, 12'd6);
            stream_frames(60, 1'b0, 1);
            send_idle_pct = 0;
            recv_idle_pct = 0;
            drain_results();
            write_sizes(8'd7, 12'd9);
            stream_frames(200, 1'b1, 2);
            drain_results();
         end
         begin
            while (stall_cycles < STALL_LIMIT) @(posedge clock);
            timed_out = 1'b1;
         end
      join_any
      disable fork;

      fails = fail_count;
      if (pending_results != 0) begin
         $display("%0d predicted result words never arrived", pending_results);
         fails++;
      end
      if (timed_out)
         $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("Covered %0d pixels under %0d size settings, clamped and shrunk mid-frame;",
               pixels_sent, settings_used);
      $display("%0d result words checked, %0d frame ends, %0d mismatches.",
               results_checked, frame_ends_seen, fails);
      if (!timed_out && fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
